>>> hw/rtl/bmhq_pkg.sv
`timescale 1ns / 1ps
package bmhq_pkg;
  localparam int unsigned MaxEntriesDefault = 1024;
  localparam int unsigned CapWidth = 11;
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusOverflow  = 2'd1;
  localparam logic [1:0] StatusUnderflow = 2'd2;
  localparam logic CmdEnqueue = 1'b0;
  localparam logic CmdDequeue = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] entry_vertex;
    logic [31:0] entry_key;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_vertex;
    logic [31:0] out_key;
    logic        now_empty;
  } rsp_t;

  typedef struct packed {
    logic [15:0] vertex;
    logic [31:0] key;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle, StUpRead, StUpCmp, StDnRead, StDnCmp, StDone
  } state_e;
endpackage

>>> hw/rtl/bmhq_ram.sv
`timescale 1ns / 1ps
module bmhq_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  bmhq_pkg::entry_t     wdata_i,
  input  logic [AddrW-1:0]     raddr_a_i,
  input  logic [AddrW-1:0]     raddr_b_i,
  output bmhq_pkg::entry_t     rdata_a_o,
  output bmhq_pkg::entry_t     rdata_b_o
);
  import bmhq_pkg::*;
  entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule

>>> hw/rtl/binary_min_heap_queue.sv
`timescale 1ns / 1ps
// Binary min-heap priority queue, one request at a time (busy high while working).
// Enqueue sifts the new entry up from the end; dequeue returns the root and sifts the last
// entry down from the root (no sift when it empties the heap); overflow/underflow leave the heap as is.
// A new request is accepted only after the previous one is done, a limit set by the
// read-compare-write loop over the single heap memory. Results strobe once; no stall.
// Reset (asynchronous, active low) empties the heap; memory contents stay undefined.
module binary_min_heap_queue #(
  parameter int unsigned MAX_ENTRIES = bmhq_pkg::MaxEntriesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bmhq_pkg::req_t  req_i,
  output logic            done_o,
  output bmhq_pkg::rsp_t  rsp_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [1:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import bmhq_pkg::*;

  // heap positions are one-based; memory address = position - 1
  localparam int unsigned AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned PosW  = CntW + 1; // room for child position 2*pos+1

  state_e state_q, state_d;
  logic [CapWidth-1:0] cap_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [PosW-1:0]     pos_q, pos_d;
  entry_t              cur_q, cur_d;   // entry being sifted, held in registers
  rsp_t                rsp_q, rsp_d;

  // memory port signals
  logic             we;
  logic [PosW-1:0]  wpos, rpos_a, rpos_b;
  entry_t           wdata, rd_a, rd_b;

  bmhq_ram #(.Depth(MAX_ENTRIES), .AddrW(AddrW)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (AddrW'(wpos - PosW'(1))),
    .wdata_i   (wdata),
    .raddr_a_i (AddrW'(rpos_a - PosW'(1))),
    .raddr_b_i (AddrW'(rpos_b - PosW'(1))),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {{(32-CapWidth){1'b0}}, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapWidth'(1024);
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      cap_q <= pwdata[CapWidth-1:0];
    end
  end

  // effective capacity: min(cap, MAX_ENTRIES)
  logic full;
  always_comb begin
    if ((CntW + 1)'(count_q) >= (CntW + 1)'(MAX_ENTRIES)) full = 1'b1;
    else full = (32'(count_q) >= 32'(cap_q));
  end

  logic [PosW-1:0] parent, lpos, rposn, cnt_w;
  assign parent = pos_q >> 1;
  assign lpos   = {pos_q[PosW-2:0], 1'b0};
  assign rposn  = {pos_q[PosW-2:0], 1'b1};
  assign cnt_w  = PosW'(count_q);

  logic accept;
  assign accept = start && !busy;

  always_comb begin
    logic l_ok, r_ok;
    logic [31:0] best_key;
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    cur_d   = cur_q;
    rsp_d   = rsp_q;
    we      = 1'b0;
    wpos    = pos_q;
    wdata   = cur_q;
    rpos_a  = parent;
    rpos_b  = rposn;
    l_ok    = 1'b0;
    r_ok    = 1'b0;
    best_key = cur_q.key;
    case (state_q)
      StIdle: begin
        rpos_a = PosW'(1);
        rpos_b = cnt_w;
        if (accept) begin
          rsp_d = '0;
          if (req_i.command == CmdEnqueue) begin
            if (full) begin
              rsp_d.status = StatusOverflow;
              rsp_d.now_empty = (count_q == '0);
              state_d = StDone;
            end else begin
              cur_d   = '{vertex: req_i.entry_vertex, key: req_i.entry_key};
              count_d = count_q + CntW'(1);
              pos_d   = cnt_w + PosW'(1);
              state_d = StUpRead;
            end
          end else begin
            if (count_q == '0) begin
              rsp_d.status = StatusUnderflow;
              rsp_d.now_empty = 1'b1;
              state_d = StDone;
            end else begin
              // root and last entry are read this cycle
              count_d = count_q - CntW'(1);
              pos_d   = PosW'(1);
              state_d = StDnRead;
            end
          end
        end
      end
      StUpRead: begin
        // read parent
        rpos_a = parent;
        if (pos_q == PosW'(1)) begin
          we = 1'b1;
          rsp_d.now_empty = 1'b0;
          state_d = StDone;
        end else begin
          state_d = StUpCmp;
        end
      end
      StUpCmp: begin
        if (cur_q.key < rd_a.key) begin
          we = 1'b1; wdata = rd_a;      // parent moves down
          pos_d = parent;
          state_d = StUpRead;
        end else begin
          we = 1'b1;
          rsp_d.now_empty = 1'b0;
          state_d = StDone;
        end
      end
      StDnRead: begin
        rpos_a = lpos;
        rpos_b = rposn;
        state_d = StDnCmp;
        if (pos_q == PosW'(1)) begin
          // first pass: memory outputs hold root and last entry
          rsp_d.out_vertex = rd_a.vertex;
          rsp_d.out_key    = rd_a.key;
          cur_d = rd_b;
          rsp_d.now_empty = (count_q == '0);
          if (count_q == '0) state_d = StDone;
        end
      end
      StDnCmp: begin
        l_ok = (lpos <= cnt_w) && (rd_a.key < cur_q.key);
        if (l_ok) best_key = rd_a.key;
        r_ok = (rposn <= cnt_w) && (rd_b.key < best_key);
        we = 1'b1;
        if (r_ok) begin
          wdata = rd_b; pos_d = rposn; state_d = StDnRead;
        end else if (l_ok) begin
          wdata = rd_a; pos_d = lpos; state_d = StDnRead;
        end else begin
          state_d = StDone;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != StIdle);
  assign done_o = (state_q == StDone);
  assign rsp_o  = rsp_q;
endmodule
